@@ design/i2c_register_access_sequencer_assert.svh @@
// Assertion macros for the I2C register access sequencer.
// Included by the modules that check their own logic; no other dependencies.
`ifndef I2C_REGISTER_ACCESS_SEQUENCER_ASSERT_SVH
`define I2C_REGISTER_ACCESS_SEQUENCER_ASSERT_SVH
`ifndef SYNTH
`define I2CRAS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
`define I2CRAS_NEVER(lbl, clk, rstn, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) else $error(msg);
`else
`define I2CRAS_ASSERT(lbl, clk, rstn, prop, msg)
`define I2CRAS_NEVER(lbl, clk, rstn, expr, msg)
`endif
`endif

@@ design/i2cras_pkg.sv @@
// Shared types and constants for the I2C register access sequencer.
// No dependencies.
`timescale 1ns / 1ps
package i2cras_pkg;

  typedef enum logic [2:0] {
    CMD_NONE   = 3'd0,
    CMD_START  = 3'd1,
    CMD_SEND   = 3'd2,
    CMD_RSTART = 3'd3,
    CMD_RECV   = 3'd4,
    CMD_NACK   = 3'd5,
    CMD_STOP   = 3'd6
  } cmd_e;

  localparam logic [1:0] ERR_OK       = 2'd0;
  localparam logic [1:0] ERR_DEV_NAK  = 2'd1;
  localparam logic [1:0] ERR_RDEV_NAK = 2'd2;
  localparam logic [1:0] ERR_DATA_NAK = 2'd3;

  localparam logic [7:0] DIR_CLEAR = 8'hFE;
  localparam logic [7:0] DIR_READ  = 8'h01;

  localparam logic REQ_START = 1'b0;

  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] send_byte;
    logic [7:0] read_data;
    logic       done;
    logic [1:0] error;
  } res_t;

endpackage

@@ design/i2cras_seq.sv @@
// Sequencer state and single-pass step logic for one request or bus event.
// Depends on i2cras_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "i2c_register_access_sequencer_assert.svh"
module i2cras_seq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic              req_type_i,
  input  logic [7:0]        device_byte_i,
  input  logic [7:0]        reg_address_i,
  input  logic              read_not_write_i,
  input  logic [7:0]        write_data_i,
  input  logic              nak_seen_i,
  input  logic [7:0]        received_byte_i,
  output i2cras_pkg::res_t  res_o
);

  typedef enum logic [3:0] {
    PH_DEV       = 4'd0,
    PH_ADDR      = 4'd1,
    PH_CHK_ADDR  = 4'd2,
    PH_RDEV      = 4'd3,
    PH_CHK_RDEV  = 4'd4,
    PH_RECV      = 4'd5,
    PH_NACK      = 4'd6,
    PH_RD_END    = 4'd7,
    PH_CHK_DATA  = 4'd10,
    PH_WR_END    = 4'd11,
    PH_IDLE      = 4'd12
  } phase_e;

  phase_e           phase_q, phase_d;
  logic             dir_q, dir_d;
  logic [7:0]       dev_q, dev_d;
  logic [7:0]       adr_q, adr_d;
  logic [7:0]       wd_q, wd_d;
  logic [7:0]       rd_q, rd_d;
  logic [1:0]       err_q, err_d;
  logic             done_q, done_d;
  i2cras_pkg::cmd_e cmd;
  logic [7:0]       tx;

  always_comb begin
    phase_d = phase_q;
    dir_d   = dir_q;
    dev_d   = dev_q;
    adr_d   = adr_q;
    wd_d    = wd_q;
    rd_d    = rd_q;
    err_d   = err_q;
    done_d  = done_q;
    cmd     = i2cras_pkg::CMD_NONE;
    tx      = 8'h00;
    if (req_type_i == i2cras_pkg::REQ_START) begin
      dev_d   = device_byte_i;
      adr_d   = reg_address_i;
      dir_d   = read_not_write_i;
      wd_d    = write_data_i;
      err_d   = i2cras_pkg::ERR_OK;
      done_d  = 1'b0;
      phase_d = PH_DEV;
      cmd     = i2cras_pkg::CMD_START;
    end else begin
      case (phase_q)
        PH_DEV: begin
          cmd     = i2cras_pkg::CMD_SEND;
          tx      = dev_q & i2cras_pkg::DIR_CLEAR;
          phase_d = PH_ADDR;
        end
        PH_ADDR: begin
          cmd     = i2cras_pkg::CMD_SEND;
          tx      = adr_q;
          phase_d = PH_CHK_ADDR;
        end
        PH_CHK_ADDR: begin
          if (nak_seen_i) begin
            err_d   = i2cras_pkg::ERR_DEV_NAK;
            done_d  = 1'b1;
            phase_d = PH_IDLE;
          end else if (dir_q) begin
            cmd     = i2cras_pkg::CMD_RSTART;
            phase_d = PH_RDEV;
          end else begin
            cmd     = i2cras_pkg::CMD_SEND;
            tx      = wd_q;
            phase_d = PH_CHK_DATA;
          end
        end
        PH_RDEV: begin
          cmd     = i2cras_pkg::CMD_SEND;
          tx      = dev_q | i2cras_pkg::DIR_READ;
          phase_d = PH_CHK_RDEV;
        end
        PH_CHK_RDEV: begin
          if (nak_seen_i) begin
            err_d   = i2cras_pkg::ERR_RDEV_NAK;
            done_d  = 1'b1;
            phase_d = PH_IDLE;
          end else begin
            cmd     = i2cras_pkg::CMD_RECV;
            phase_d = PH_RECV;
          end
        end
        PH_RECV: begin
          rd_d    = received_byte_i;
          cmd     = i2cras_pkg::CMD_NACK;
          phase_d = PH_NACK;
        end
        PH_NACK: begin
          cmd     = i2cras_pkg::CMD_STOP;
          phase_d = PH_RD_END;
        end
        PH_CHK_DATA: begin
          if (nak_seen_i) begin
            err_d   = i2cras_pkg::ERR_DATA_NAK;
            done_d  = 1'b1;
            phase_d = PH_IDLE;
          end else begin
            cmd     = i2cras_pkg::CMD_STOP;
            phase_d = PH_WR_END;
          end
        end
        PH_RD_END, PH_WR_END: begin
          err_d   = i2cras_pkg::ERR_OK;
          done_d  = 1'b1;
          phase_d = PH_IDLE;
        end
        default: begin
        end
      endcase
    end
  end

  assign res_o = '{cmd: cmd, send_byte: tx, read_data: rd_d, done: done_d, error: err_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      dir_q   <= 1'b0;
      dev_q   <= 8'h00;
      adr_q   <= 8'h00;
      wd_q    <= 8'h00;
      rd_q    <= 8'h00;
      err_q   <= i2cras_pkg::ERR_OK;
      done_q  <= 1'b0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      dir_q   <= dir_d;
      dev_q   <= dev_d;
      adr_q   <= adr_d;
      wd_q    <= wd_d;
      rd_q    <= rd_d;
      err_q   <= err_d;
      done_q  <= done_d;
    end
  end

  `I2CRAS_ASSERT(a_done_idle, clk_i, rst_ni, done_q |-> (phase_q == PH_IDLE), "done while busy")
  `I2CRAS_ASSERT(a_err_done, clk_i, rst_ni, (err_q != i2cras_pkg::ERR_OK) |-> done_q, "error without done")
  `I2CRAS_ASSERT(a_start_clears, clk_i, rst_ni, (accept_i && (req_type_i == i2cras_pkg::REQ_START)) |=> (!done_q && (phase_q == PH_DEV) && (err_q == i2cras_pkg::ERR_OK)), "start did not restart sequence")

endmodule

@@ design/i2cras_out_buf.sv @@
// Two-entry output buffer (output register plus skid register) for result words.
// Depends on i2cras_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "i2c_register_access_sequencer_assert.svh"
module i2cras_out_buf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  i2cras_pkg::res_t  push_data_i,
  output logic              push_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output i2cras_pkg::res_t  out_data_o
);

  logic             main_valid_q;
  logic             skid_valid_q;
  i2cras_pkg::res_t main_q;
  i2cras_pkg::res_t skid_q;
  logic             pop;

  assign pop          = main_valid_q & out_ready_i;
  assign push_ready_o = ~skid_valid_q;
  assign out_valid_o  = main_valid_q;
  assign out_data_o   = main_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (pop) begin
      if (skid_valid_q) begin
        skid_valid_q <= 1'b0;
      end else begin
        main_valid_q <= push_i;
      end
    end else if (push_i) begin
      if (main_valid_q) begin
        skid_valid_q <= 1'b1;
      end else begin
        main_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      if (skid_valid_q) begin
        main_q <= skid_q;
      end else if (push_i) begin
        main_q <= push_data_i;
      end
    end else if (push_i) begin
      if (main_valid_q) begin
        skid_q <= push_data_i;
      end else begin
        main_q <= push_data_i;
      end
    end
  end

  `I2CRAS_ASSERT(a_skid_main, clk_i, rst_ni, skid_valid_q |-> main_valid_q, "skid filled while output empty")
  `I2CRAS_NEVER(a_no_overflow, clk_i, rst_ni, push_i && skid_valid_q, "push into full buffer")
  `I2CRAS_ASSERT(a_stall_skid, clk_i, rst_ni, (main_valid_q && !out_ready_i && push_i && !skid_valid_q) |=> skid_valid_q, "stalled push lost")

endmodule

@@ design/i2c_register_access_sequencer.sv @@
// I2C register access sequencer: top level joining the step logic and the output buffer.
// Depends on i2cras_pkg, i2cras_seq and i2cras_out_buf.
`timescale 1ns / 1ps
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries a start request (req_type_i = 0,
//   with device byte, register address, direction and write data) or a bus-complete
//   event (req_type_i = 1, with the NAK flag and the received byte).
//   Each accepted word gives exactly one result word on the output channel
//   (out_valid_o / out_ready_i): next bus command, byte to send, read data,
//   done and error code.
//   Each result word is registered in the output buffer when its input word is accepted.
//   Throughput: one word per cycle while in_ready_o is high; the step logic between
//   the sequencer state registers and the output register sets this figure.
//   When the receiver stalls, the output register holds its word and a skid
//   register takes one more; in_ready_o drops only while the skid register is full,
//   and rises again once the receiver takes a word.
//   Reset: the sequencer goes idle with done and error cleared and read data zero;
//   both output entries are empty. Events while idle return a word with no command.
//   A start request while a sequence runs drops it and begins a new one.
module i2c_register_access_sequencer (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       req_type_i,
  input  logic [7:0] device_byte_i,
  input  logic [7:0] reg_address_i,
  input  logic       read_not_write_i,
  input  logic [7:0] write_data_i,
  input  logic       nak_seen_i,
  input  logic [7:0] received_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] bus_command_o,
  output logic [7:0] send_byte_o,
  output logic [7:0] read_data_o,
  output logic       done_res_o,
  output logic [1:0] error_code_o
);

  logic             accept;
  i2cras_pkg::res_t step_res;
  i2cras_pkg::res_t out_res;

  assign accept = in_valid_i & in_ready_o;

  i2cras_seq u_seq (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .accept_i         (accept),
    .req_type_i       (req_type_i),
    .device_byte_i    (device_byte_i),
    .reg_address_i    (reg_address_i),
    .read_not_write_i (read_not_write_i),
    .write_data_i     (write_data_i),
    .nak_seen_i       (nak_seen_i),
    .received_byte_i  (received_byte_i),
    .res_o            (step_res)
  );

  i2cras_out_buf u_out_buf (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (accept),
    .push_data_i  (step_res),
    .push_ready_o (in_ready_o),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_res)
  );

  assign bus_command_o = 3'(out_res.cmd);
  assign send_byte_o   = out_res.send_byte;
  assign read_data_o   = out_res.read_data;
  assign done_res_o    = out_res.done;
  assign error_code_o  = out_res.error;

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the I2C register access sequencer.
// Predicts every result word from the accepted request and event words.
// Depends on i2cras_pkg and i2c_register_access_sequencer.
`timescale 1ns / 1ps
module tb_top;

  localparam int TOTAL_WORDS  = 1150;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 20;
  localparam int LONG_HOLD    = 120;
  localparam int MAX_REPORTS  = 10;
  localparam int READ_EVENTS  = 8;
  localparam int WRITE_EVENTS = 5;

  typedef enum logic [3:0] {
    SQ_SEND_DEV   = 4'd0,
    SQ_SEND_ADR   = 4'd1,
    SQ_CHECK_ADR  = 4'd2,
    SQ_SEND_RDEV  = 4'd3,
    SQ_CHECK_RDEV = 4'd4,
    SQ_CAPTURE    = 4'd5,
    SQ_STOP_RD    = 4'd6,
    SQ_FINISH_RD  = 4'd7,
    SQ_CHECK_DATA = 4'd10,
    SQ_FINISH_WR  = 4'd11,
    SQ_IDLE       = 4'd12
  } phase_e;

  typedef struct packed {
    logic       req_type;
    logic [7:0] device_byte;
    logic [7:0] reg_address;
    logic       read_not_write;
    logic [7:0] write_data;
    logic       nak_seen;
    logic [7:0] received_byte;
  } bus_word_t;

  logic       clk_i            = 1'b0;
  logic       rst_ni           = 1'b0;
  logic       in_valid_i       = 1'b0;
  logic       in_ready_o;
  logic       req_type_i       = 1'b0;
  logic [7:0] device_byte_i    = 8'h00;
  logic [7:0] reg_address_i    = 8'h00;
  logic       read_not_write_i = 1'b0;
  logic [7:0] write_data_i     = 8'h00;
  logic       nak_seen_i       = 1'b0;
  logic [7:0] received_byte_i  = 8'h00;
  logic       out_valid_o;
  logic       out_ready_i      = 1'b0;
  logic [2:0] bus_command_o;
  logic [7:0] send_byte_o;
  logic [7:0] read_data_o;
  logic       done_res_o;
  logic [1:0] error_code_o;

  phase_e     seq_phase = SQ_IDLE;
  logic       seq_read  = 1'b0;
  logic [7:0] seq_dev   = 8'h00;
  logic [7:0] seq_adr   = 8'h00;
  logic [7:0] seq_wdata = 8'h00;
  logic [7:0] seq_rdata = 8'h00;
  logic [1:0] seq_err   = i2cras_pkg::ERR_OK;
  logic       seq_done  = 1'b0;

  i2cras_pkg::res_t awaited_results[$];
  int   fail_count   = 0;
  int   cycle_count  = 0;
  int   sent_words   = 0;
  int   hold_cycles  = 0;
  bit   no_idle      = 1'b0;

  always #2 clk_i = ~clk_i;

  i2c_register_access_sequencer i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .req_type_i       (req_type_i),
    .device_byte_i    (device_byte_i),
    .reg_address_i    (reg_address_i),
    .read_not_write_i (read_not_write_i),
    .write_data_i     (write_data_i),
    .nak_seen_i       (nak_seen_i),
    .received_byte_i  (received_byte_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .bus_command_o    (bus_command_o),
    .send_byte_o      (send_byte_o),
    .read_data_o      (read_data_o),
    .done_res_o       (done_res_o),
    .error_code_o     (error_code_o)
  );

  function automatic void end_sequence(input logic [1:0] code);
    seq_err   = code;
    seq_done  = 1'b1;
    seq_phase = SQ_IDLE;
  endfunction

  function automatic i2cras_pkg::res_t advance_sequencer(input bus_word_t w);
    i2cras_pkg::res_t r;
    r.cmd       = i2cras_pkg::CMD_NONE;
    r.send_byte = 8'h00;
    if (w.req_type == i2cras_pkg::REQ_START) begin
      seq_dev   = w.device_byte;
      seq_adr   = w.reg_address;
      seq_read  = w.read_not_write;
      seq_wdata = w.write_data;
      seq_err   = i2cras_pkg::ERR_OK;
      seq_done  = 1'b0;
      seq_phase = SQ_SEND_DEV;
      r.cmd     = i2cras_pkg::CMD_START;
    end else begin
      case (seq_phase)
        SQ_SEND_DEV: begin
          r.cmd       = i2cras_pkg::CMD_SEND;
          r.send_byte = seq_dev & i2cras_pkg::DIR_CLEAR;
          seq_phase   = SQ_SEND_ADR;
        end
        SQ_SEND_ADR: begin
          r.cmd       = i2cras_pkg::CMD_SEND;
          r.send_byte = seq_adr;
          seq_phase   = SQ_CHECK_ADR;
        end
        SQ_CHECK_ADR: begin
          if (w.nak_seen) begin
            end_sequence(i2cras_pkg::ERR_DEV_NAK);
          end else if (seq_read) begin
            r.cmd     = i2cras_pkg::CMD_RSTART;
            seq_phase = SQ_SEND_RDEV;
          end else begin
            r.cmd       = i2cras_pkg::CMD_SEND;
            r.send_byte = seq_wdata;
            seq_phase   = SQ_CHECK_DATA;
          end
        end
        SQ_SEND_RDEV: begin
          r.cmd       = i2cras_pkg::CMD_SEND;
          r.send_byte = seq_dev | i2cras_pkg::DIR_READ;
          seq_phase   = SQ_CHECK_RDEV;
        end
        SQ_CHECK_RDEV: begin
          if (w.nak_seen) begin
            end_sequence(i2cras_pkg::ERR_RDEV_NAK);
          end else begin
            r.cmd     = i2cras_pkg::CMD_RECV;
            seq_phase = SQ_CAPTURE;
          end
        end
        SQ_CAPTURE: begin
          seq_rdata = w.received_byte;
          r.cmd     = i2cras_pkg::CMD_NACK;
          seq_phase = SQ_STOP_RD;
        end
        SQ_STOP_RD: begin
          r.cmd     = i2cras_pkg::CMD_STOP;
          seq_phase = SQ_FINISH_RD;
        end
        SQ_FINISH_RD: begin
          end_sequence(i2cras_pkg::ERR_OK);
        end
        SQ_CHECK_DATA: begin
          if (w.nak_seen) begin
            end_sequence(i2cras_pkg::ERR_DATA_NAK);
          end else begin
            r.cmd     = i2cras_pkg::CMD_STOP;
            seq_phase = SQ_FINISH_WR;
          end
        end
        SQ_FINISH_WR: begin
          end_sequence(i2cras_pkg::ERR_OK);
        end
        default: begin
        end
      endcase
    end
    r.read_data = seq_rdata;
    r.done      = seq_done;
    r.error     = seq_err;
    return r;
  endfunction

  function automatic bus_word_t random_word();
    bus_word_t w;
    w.req_type       = 1'($urandom_range(0, 1));
    w.device_byte    = 8'($urandom_range(0, 255));
    w.reg_address    = 8'($urandom_range(0, 255));
    w.read_not_write = 1'($urandom_range(0, 1));
    w.write_data     = 8'($urandom_range(0, 255));
    w.nak_seen       = 1'($urandom_range(0, 1));
    w.received_byte  = 8'($urandom_range(0, 255));
    return w;
  endfunction

  task automatic send_word(input bus_word_t w);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    req_type_i       <= w.req_type;
    device_byte_i    <= w.device_byte;
    reg_address_i    <= w.reg_address;
    read_not_write_i <= w.read_not_write;
    write_data_i     <= w.write_data;
    nak_seen_i       <= w.nak_seen;
    received_byte_i  <= w.received_byte;
    do begin
      @(posedge clk_i);
    end while (!in_ready_o);
    sent_words++;
    awaited_results.push_back(advance_sequencer(w));
  endtask

  task automatic send_start(input logic [7:0] dev, input logic [7:0] adr,
                            input logic rnw, input logic [7:0] wd);
    bus_word_t w;
    w                = '0;
    w.req_type       = i2cras_pkg::REQ_START;
    w.device_byte    = dev;
    w.reg_address    = adr;
    w.read_not_write = rnw;
    w.write_data     = wd;
    send_word(w);
  endtask

  task automatic send_event(input logic nak, input logic [7:0] rx);
    bus_word_t w;
    w               = '0;
    w.req_type      = ~i2cras_pkg::REQ_START;
    w.nak_seen      = nak;
    w.received_byte = rx;
    send_word(w);
  endtask

  task automatic send_random_sequence();
    bus_word_t w;
    int        n_events;
    w          = random_word();
    w.req_type = i2cras_pkg::REQ_START;
    send_word(w);
    n_events = w.read_not_write ? READ_EVENTS : WRITE_EVENTS;
    case ($urandom_range(0, 7))
      0: begin
        n_events = $urandom_range(0, n_events - 1);
      end
      1: begin
        n_events += $urandom_range(1, 2);
      end
      default: begin
      end
    endcase
    repeat (n_events) begin
      w          = random_word();
      w.req_type = ~i2cras_pkg::REQ_START;
      w.nak_seen = ($urandom_range(0, 7) == 0);
      if ($urandom_range(0, 31) == 0) begin
        w.req_type = 1'($urandom_range(0, 1));
      end
      send_word(w);
    end
  endtask

  task automatic test_write_path();
    send_start(8'hFF, 8'h00, 1'b0, 8'hA5);
    send_event(1'b0, 8'h00);
    send_event(1'b1, 8'h00);
    send_event(1'b0, 8'hFF);
    send_event(1'b0, 8'h00);
    send_event(1'b1, 8'hFF);
  endtask

  task automatic test_read_path();
    send_start(8'h00, 8'hFF, 1'b1, 8'h00);
    send_event(1'b0, 8'h00);
    send_event(1'b0, 8'h00);
    send_event(1'b0, 8'h00);
    send_event(1'b0, 8'h00);
    send_event(1'b0, 8'h00);
    send_event(1'b0, 8'hFF);
    send_event(1'b1, 8'h00);
    send_event(1'b0, 8'h00);
  endtask

  task automatic test_restart_and_nak();
    send_start(8'h3C, 8'hA5, 1'b1, 8'h5A);
    send_event(1'b0, 8'h00);
    send_start(8'hC3, 8'h5A, 1'b0, 8'h96);
    send_event(1'b0, 8'h00);
    send_event(1'b0, 8'h00);
    send_event(1'b1, 8'h00);
    send_event(1'b1, 8'hFF);
  endtask

  task automatic test_output_stall();
    no_idle     = 1'b1;
    hold_cycles = LONG_HOLD;
    repeat (3) send_random_sequence();
    no_idle = 1'b0;
  endtask

  task automatic test_random_sequences();
    while (sent_words < TOTAL_WORDS) begin
      if ($urandom_range(0, 15) == 0) begin
        no_idle = 1'b1;
        repeat (4) send_random_sequence();
        no_idle = 1'b0;
      end else begin
        send_random_sequence();
      end
    end
  endtask

  initial begin : drive_ready
    int gap;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_cycles > 0) begin
        gap         = hold_cycles;
        hold_cycles = 0;
      end else begin
        gap = no_idle ? 0 : $urandom_range(0, 4);
      end
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do begin
        @(posedge clk_i);
      end while (!out_valid_o);
    end
  end

  always @(posedge clk_i) begin : check_results
    i2cras_pkg::res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (awaited_results.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS) begin
          $display("unexpected result word: cmd=%0d tx=%02h rd=%02h done=%0d err=%0d",
                   bus_command_o, send_byte_o, read_data_o, done_res_o, error_code_o);
        end
      end else begin
        want = awaited_results.pop_front();
        if (bus_command_o !== want.cmd || send_byte_o !== want.send_byte ||
            read_data_o !== want.read_data || done_res_o !== want.done ||
            error_code_o !== want.error) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS) begin
            $display("result mismatch: exp cmd=%0d tx=%02h rd=%02h done=%0d err=%0d",
                     want.cmd, want.send_byte, want.read_data, want.done, want.error);
            $display("                 got cmd=%0d tx=%02h rd=%02h done=%0d err=%0d",
                     bus_command_o, send_byte_o, read_data_o, done_res_o, error_code_o);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_write_path();
    test_read_path();
    test_restart_and_nak();
    test_output_stall();
    test_random_sequences();
    in_valid_i <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && awaited_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
